// ===== rtl/core/lztd_pkg.sv =====
// Package for the LZ token stream decoder: default parameters, code
// constants, result kinds and sequencer states. Depends on nothing.
package lztd_pkg;

  localparam int DEF_HISTORY_DEPTH = 65536;
  localparam int DEF_MAX_MATCH     = 64;
  localparam int DEF_LENGTH_BIAS   = 257;

  localparam int          COUNT_W   = 17;
  localparam logic [31:0] END_CODE  = 32'd256;
  localparam logic [16:0] CAP_LIMIT = 17'h10000;

  typedef enum logic [2:0] {
    KIND_BYTE        = 3'd0,
    KIND_END         = 3'd1,
    KIND_OVERFLOW    = 3'd2,
    KIND_BAD_DIST    = 3'd3,
    KIND_MISSING_END = 3'd4,
    KIND_BAD_LENGTH  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WRITE
  } state_t;

endpackage

// ===== rtl/core/lztd_in_if.sv =====
// Input channel of the LZ token stream decoder: one code word per transfer.
// Depends on nothing.
interface lztd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        final_word;

  modport source (output valid, output code_word, output final_word, input ready);
  modport sink   (input valid, input code_word, input final_word, output ready);
endinterface

// ===== rtl/core/lztd_out_if.sv =====
// Result channel of the LZ token stream decoder: one result word per transfer.
// Depends on nothing.
interface lztd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [16:0] byte_count;
  logic        run_last;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_count,
                  input run_last, output ready);
endinterface

// ===== rtl/core/lz_token_stream_decoder_unit.sv =====
// Top level of the LZ token stream decoder. Uses lztd_pkg, lztd_in_if,
// lztd_out_if and lztd_history.

// The decoder takes one code word at a time and is not ready again until
// that word is fully handled. A literal, end code or length code is
// accepted and then decoded; a distance word is accepted, decoded and then
// copied byte by byte: each match byte is first read from the single read
// port of the history memory, then written back and sent out from the write
// state, which is what lets a copy overlap its own output. Results leave
// through an output register, so a new word can be accepted while the last
// result still waits to be taken; decoding and copying stall while that
// register is full and not being emptied, even for a word with no result.
// The history memory is not cleared at reset: a stream can only read back
// bytes it has written itself, so its contents before the first write do
// not matter. The capacity register may be written only while the decoder
// is idle; values above 65536 act as 65536.
module lz_token_stream_decoder_unit #(
  parameter int HISTORY_DEPTH = lztd_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_MATCH     = lztd_pkg::DEF_MAX_MATCH,
  parameter int LENGTH_BIAS   = lztd_pkg::DEF_LENGTH_BIAS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [16:0]       cfg_wr_data,
  lztd_in_if.sink           words,
  lztd_out_if.source        results
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = $clog2(MAX_MATCH + 1);

  lztd_pkg::state_t state, state_next;

  // Word being decoded, captured on accept.
  logic [31:0] word;
  logic        fin;

  logic [16:0]   capacity;
  logic [16:0]   cap_eff;
  logic [16:0]   written_count, written_count_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [AW:0]   back_diff;
  logic [LW-1:0] pending_length, pending_length_next;
  logic [LW-1:0] copy_left, copy_left_next;
  logic          awaiting_distance, awaiting_distance_next;
  logic          discarding, discarding_next;

  // Output register.
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [16:0] out_count;
  logic        out_last;
  logic        out_free;
  logic        out_load;
  logic [2:0]  ld_kind;
  logic [7:0]  ld_byte;
  logic [16:0] ld_count;
  logic        ld_last;

  // History memory port.
  logic       mem_we;
  logic [7:0] mem_wdata;
  logic [7:0] mem_rdata;

  // Decode comparisons on the captured word and the stream counters.
  logic [32:0] len_excess;
  logic        match_overflow;
  logic        dist_bad;
  logic        length_bad;

  lztd_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (mem_wdata),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  assign cap_eff = (capacity > lztd_pkg::CAP_LIMIT) ? lztd_pkg::CAP_LIMIT : capacity;

  assign wr_ptr_inc = (wr_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // Source of a match: the write pointer stepped back by the distance,
  // wrapping around the history depth. Only used once the distance is
  // known to be no larger than the depth.
  always_comb begin
    if ({1'b0, wr_ptr} >= word[AW:0]) begin
      back_diff = {1'b0, wr_ptr} - word[AW:0];
    end else begin
      back_diff = {1'b0, wr_ptr} + (AW+1)'(HISTORY_DEPTH) - word[AW:0];
    end
  end

  assign len_excess     = {1'b0, word} - 33'(LENGTH_BIAS);
  assign length_bad     = (word < 32'(LENGTH_BIAS)) || (len_excess > 33'(MAX_MATCH));
  assign match_overflow = ({1'b0, written_count} + 18'(pending_length)) > {1'b0, cap_eff};
  assign dist_bad       = (word == '0) || (word > {15'b0, written_count}) ||
                          ({1'b0, word} > 33'(HISTORY_DEPTH));

  assign words.ready = (state == lztd_pkg::ST_IDLE);
  assign out_free    = !out_valid || results.ready;

  // Sequencer: next state, stream state and the result to load.
  always_comb begin
    state_next             = state;
    written_count_next     = written_count;
    wr_ptr_next            = wr_ptr;
    rd_ptr_next            = rd_ptr;
    pending_length_next    = pending_length;
    copy_left_next         = copy_left;
    awaiting_distance_next = awaiting_distance;
    discarding_next        = discarding;
    out_load               = 1'b0;
    ld_kind                = lztd_pkg::KIND_BYTE;
    ld_byte                = '0;
    ld_count               = '0;
    ld_last                = 1'b1;
    mem_we                 = 1'b0;
    mem_wdata              = word[7:0];

    unique case (state)
      lztd_pkg::ST_IDLE: begin
        if (words.valid) begin
          state_next = lztd_pkg::ST_DECODE;
        end
      end

      lztd_pkg::ST_DECODE: begin
        if (out_free) begin
          state_next = lztd_pkg::ST_IDLE;
          ld_count   = written_count;
          if (discarding) begin
            // Skip words up to and including the last word of the stream.
            if (fin) begin
              discarding_next        = 1'b0;
              written_count_next     = '0;
              wr_ptr_next            = '0;
              pending_length_next    = '0;
              awaiting_distance_next = 1'b0;
            end
          end else if (fin && (awaiting_distance || word != lztd_pkg::END_CODE)) begin
            out_load               = 1'b1;
            ld_kind                = lztd_pkg::KIND_MISSING_END;
            written_count_next     = '0;
            wr_ptr_next            = '0;
            pending_length_next    = '0;
            awaiting_distance_next = 1'b0;
          end else if (awaiting_distance || word > lztd_pkg::END_CODE) begin
            // A distance word, or a length code. Errors restart the stream.
            awaiting_distance_next = 1'b0;
            pending_length_next    = '0;
            if (awaiting_distance) begin
              if (match_overflow || dist_bad) begin
                out_load           = 1'b1;
                ld_kind            = match_overflow ? lztd_pkg::KIND_OVERFLOW
                                                    : lztd_pkg::KIND_BAD_DIST;
                written_count_next = '0;
                wr_ptr_next        = '0;
                discarding_next    = 1'b1;
              end else if (pending_length != '0) begin
                rd_ptr_next    = back_diff[AW-1:0];
                copy_left_next = pending_length;
                state_next     = lztd_pkg::ST_READ;
              end
            end else if (length_bad) begin
              out_load           = 1'b1;
              ld_kind            = lztd_pkg::KIND_BAD_LENGTH;
              written_count_next = '0;
              wr_ptr_next        = '0;
              discarding_next    = 1'b1;
            end else begin
              pending_length_next    = len_excess[LW-1:0];
              awaiting_distance_next = 1'b1;
            end
          end else if (word == lztd_pkg::END_CODE) begin
            out_load           = 1'b1;
            ld_kind            = lztd_pkg::KIND_END;
            written_count_next = '0;
            wr_ptr_next        = '0;
            discarding_next    = !fin;
          end else if (written_count >= cap_eff) begin
            // Literal with no room left.
            out_load           = 1'b1;
            ld_kind            = lztd_pkg::KIND_OVERFLOW;
            written_count_next = '0;
            wr_ptr_next        = '0;
            discarding_next    = 1'b1;
          end else begin
            out_load           = 1'b1;
            ld_byte            = word[7:0];
            ld_count           = '0;
            mem_we             = 1'b1;
            written_count_next = written_count + 1'b1;
            wr_ptr_next        = wr_ptr_inc;
          end
        end
      end

      lztd_pkg::ST_READ: begin
        state_next = lztd_pkg::ST_WRITE;
      end

      lztd_pkg::ST_WRITE: begin
        if (out_free) begin
          out_load           = 1'b1;
          ld_byte            = mem_rdata;
          ld_last            = (copy_left == LW'(1));
          mem_we             = 1'b1;
          mem_wdata          = mem_rdata;
          written_count_next = written_count + 1'b1;
          wr_ptr_next        = wr_ptr_inc;
          rd_ptr_next        = rd_ptr_inc;
          copy_left_next     = copy_left - 1'b1;
          state_next         = (copy_left == LW'(1)) ? lztd_pkg::ST_IDLE
                                                     : lztd_pkg::ST_READ;
        end
      end

      default: begin
        state_next = lztd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= lztd_pkg::ST_IDLE;
      capacity          <= lztd_pkg::CAP_LIMIT;
      written_count     <= '0;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      pending_length    <= '0;
      copy_left         <= '0;
      awaiting_distance <= 1'b0;
      discarding        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      written_count     <= written_count_next;
      wr_ptr            <= wr_ptr_next;
      rd_ptr            <= rd_ptr_next;
      pending_length    <= pending_length_next;
      copy_left         <= copy_left_next;
      awaiting_distance <= awaiting_distance_next;
      discarding        <= discarding_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      word <= words.code_word;
      fin  <= words.final_word;
    end
    if (out_load) begin
      out_kind  <= ld_kind;
      out_byte  <= ld_byte;
      out_count <= ld_count;
      out_last  <= ld_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.kind       = out_kind;
  assign results.data_byte  = out_byte;
  assign results.byte_count = out_count;
  assign results.run_last   = out_last;

`ifndef SYNTHESIS
  // A stream never holds more bytes than the largest capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    written_count <= lztd_pkg::CAP_LIMIT)
    else $error("written byte count above the capacity limit");

  // A copy in progress always has bytes left to move.
  a_copy_left: assert property (@(posedge clk) disable iff (rst)
    (state == lztd_pkg::ST_READ || state == lztd_pkg::ST_WRITE) |-> copy_left != '0)
    else $error("copy running with no bytes left");

  // Only match bytes can be followed by more results from the same word.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.run_last) |-> results.kind == 3'(lztd_pkg::KIND_BYTE))
    else $error("status result not marked as last");

  // Discarding a stream and waiting for a distance exclude each other.
  a_disc_await: assert property (@(posedge clk) disable iff (rst)
    !(discarding && awaiting_distance))
    else $error("discarding while a distance is pending");

  // An accepted word reaches the decode state in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (words.valid && words.ready) |=> state == lztd_pkg::ST_DECODE)
    else $error("accepted word not decoded");
`endif

endmodule

// ===== rtl/core/lztd_history.sv =====
// History memory of the LZ token stream decoder: one write port and one
// read port with registered read data. Depends on lztd_pkg.
module lztd_history #(
  parameter int DEPTH = lztd_pkg::DEF_HISTORY_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for lz_token_stream_decoder_unit: a directed table
// followed by random LZ streams, checked against typed rows or a predictor.
// Depends on lztd_pkg, lztd_in_if, lztd_out_if and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_DEPTH = lztd_pkg::DEF_HISTORY_DEPTH;
  localparam int unsigned MAX_LEN    = lztd_pkg::DEF_MAX_MATCH;
  localparam int unsigned LEN_BIAS   = lztd_pkg::DEF_LENGTH_BIAS;

  // A word that causes no result (length code, skipped word, empty match)
  // still passes through the decode state, and this margin lets it finish.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_WORDS   = 35;

  typedef struct packed {
    lztd_pkg::kind_t kind;
    logic [7:0]      data_byte;
    logic [16:0]     byte_count;
    logic            run_last;
  } result_t;

  typedef struct packed {
    logic [31:0] code_word;
    logic        final_word;
  } plan_t;

  // Rows of the directed table either write the capacity (value in code_word)
  // or send one word. Where typed is set, the result is the one written here.
  typedef enum logic {ROW_WORD, ROW_CAP} row_op_t;

  typedef struct packed {
    row_op_t         op;
    logic [31:0]     code_word;
    logic            final_word;
    logic            typed;
    lztd_pkg::kind_t kind;
    logic [7:0]      data_byte;
    logic [16:0]     byte_count;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  lztd_in_if  word_ch ();
  lztd_out_if result_ch ();

  lz_token_stream_decoder_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .words       (word_ch),
    .results     (result_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: a private copy of the decoder's history and counters.
  logic [7:0]  hist_mem [HIST_DEPTH];
  logic [16:0] cap_reg;
  int unsigned wr_count;
  int unsigned match_len;
  bit          want_dist;
  bit          skipping;

  result_t word_results [$];     // results of the word being predicted
  result_t awaited_results [$];  // results the decoder still owes us
  plan_t   word_plan [$];        // words of the stream about to be sent

  int mismatches;
  int decoded_words;             // words that reached the decoder proper
  bit src_steady;
  bit sink_steady;
  int hold_cycles;               // set by the stimulus, consumed by the sink

  // Directed table. It walks through the capacity extremes (zero, a tight
  // limit, and a 17-bit value above 65536 that must act as 65536), an
  // overlapping copy, zero and maximum match lengths, every error kind and
  // both flavors of the end code.
  row_t script_rows [$] = '{
    '{ROW_CAP,  32'd0,         1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_00A5, 1'b0, 1'b1, lztd_pkg::KIND_OVERFLOW,    8'h00, 17'd0},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_CAP,  32'd5,         1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0000, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_00FF, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'hFF, 17'd0},
    '{ROW_WORD, 32'd260,       1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd2,         1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0007, 1'b0, 1'b1, lztd_pkg::KIND_OVERFLOW,    8'h00, 17'd5},
    '{ROW_WORD, 32'd256,       1'b1, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_CAP,  32'h0001_FFFF, 1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0041, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'h41, 17'd0},
    '{ROW_WORD, 32'd257,       1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd1,         1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd321,       1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd1,         1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1, lztd_pkg::KIND_BAD_LENGTH,  8'h00, 17'd65},
    '{ROW_WORD, 32'd0,         1'b1, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0080, 1'b1, 1'b1, lztd_pkg::KIND_MISSING_END, 8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0001, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'h01, 17'd0},
    '{ROW_WORD, 32'd258,       1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd0,         1'b0, 1'b1, lztd_pkg::KIND_BAD_DIST,    8'h00, 17'd1},
    '{ROW_WORD, 32'd7,         1'b1, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0002, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'h02, 17'd0},
    '{ROW_WORD, 32'd258,       1'b0, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'd2,         1'b1, 1'b1, lztd_pkg::KIND_MISSING_END, 8'h00, 17'd1},
    '{ROW_WORD, 32'd256,       1'b0, 1'b1, lztd_pkg::KIND_END,         8'h00, 17'd0},
    '{ROW_WORD, 32'd99,        1'b1, 1'b0, lztd_pkg::KIND_BYTE,        8'h00, 17'd0},
    '{ROW_WORD, 32'h0000_0003, 1'b0, 1'b1, lztd_pkg::KIND_BYTE,        8'h03, 17'd0},
    '{ROW_WORD, 32'd256,       1'b1, 1'b1, lztd_pkg::KIND_END,         8'h00, 17'd1}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void add_result(lztd_pkg::kind_t k, logic [7:0] b, logic [16:0] n,
                                     logic last);
    result_t r;
    r.kind       = k;
    r.data_byte  = b;
    r.byte_count = n;
    r.run_last   = last;
    word_results.insert(word_results.size(), r);
  endfunction

  // A new stream forgets its byte count and any half-read match, but the
  // history memory is kept.
  function automatic void open_stream();
    wr_count  = 0;
    match_len = 0;
    want_dist = 1'b0;
  endfunction

  // Errors report the bytes decoded so far and then drop words up to the
  // next one that carries final_word.
  function automatic void abort_stream(lztd_pkg::kind_t k);
    add_result(k, 8'h00, 17'(wr_count), 1'b1);
    open_stream();
    skipping = 1'b1;
  endfunction

  function automatic void keep_byte(logic [7:0] b, logic last);
    hist_mem[wr_count % HIST_DEPTH] = b;
    wr_count++;
    add_result(lztd_pkg::KIND_BYTE, b, 17'd0, last);
  endfunction

  function automatic void decode_word(input logic [31:0] cw, input logic fin);
    int unsigned cap;
    int unsigned len;
    cap = (cap_reg > lztd_pkg::CAP_LIMIT) ? int'(lztd_pkg::CAP_LIMIT) : int'(cap_reg);
    if (skipping) begin
      if (fin) begin
        skipping = 1'b0;
        open_stream();
      end
      return;
    end
    // The last word of a coded stream must be the end code itself; anything
    // else, a pending distance included, is reported and not decoded.
    if (fin && (want_dist || cw != lztd_pkg::END_CODE)) begin
      add_result(lztd_pkg::KIND_MISSING_END, 8'h00, 17'(wr_count), 1'b1);
      open_stream();
      return;
    end
    if (want_dist) begin
      len       = match_len;
      want_dist = 1'b0;
      match_len = 0;
      // Capacity is judged before the distance.
      if (wr_count + len > cap) begin
        abort_stream(lztd_pkg::KIND_OVERFLOW);
        return;
      end
      if (cw == 0 || cw > wr_count || cw > HIST_DEPTH) begin
        abort_stream(lztd_pkg::KIND_BAD_DIST);
        return;
      end
      // Byte by byte, so a short distance repeats bytes of this same copy.
      for (int i = 0; i < len; i++)
        keep_byte(hist_mem[(wr_count - cw) % HIST_DEPTH], i == len - 1);
      return;
    end
    if (cw < lztd_pkg::END_CODE) begin
      if (wr_count >= cap)
        abort_stream(lztd_pkg::KIND_OVERFLOW);
      else
        keep_byte(cw[7:0], 1'b1);
      return;
    end
    if (cw == lztd_pkg::END_CODE) begin
      add_result(lztd_pkg::KIND_END, 8'h00, 17'(wr_count), 1'b1);
      open_stream();
      skipping = !fin;
      return;
    end
    if (cw < LEN_BIAS || cw - LEN_BIAS > MAX_LEN) begin
      abort_stream(lztd_pkg::KIND_BAD_LENGTH);
      return;
    end
    match_len = cw - LEN_BIAS;
    want_dist = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result word: kind %0d, data_byte %0d, byte_count %0d",
               result_ch.kind, result_ch.data_byte, result_ch.byte_count);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (result_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, result_ch.kind);
          mismatches++;
        end
        if (result_ch.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0d, got %0d", want.data_byte, result_ch.data_byte);
          mismatches++;
        end
        if (result_ch.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count,
                 result_ch.byte_count);
          mismatches++;
        end
        if (result_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, result_ch.run_last);
          mismatches++;
        end
      end
    end
  end

  // The result sink. It drops ready at random, never during a steady stretch,
  // and on request it stalls for a long, counted stretch so that the output
  // register fills and the decoder has to stop taking words.
  initial begin : result_sink
    int stall;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= sink_steady || ($urandom_range(0, 99) >= 37);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offers one word and waits for it to be taken. All drives happen right
  // after a rising edge; valid stays high into the next word unless a gap
  // is drawn, so it is never lowered and raised in one time step.
  task automatic send_word(input logic [31:0] cw, input logic fin, input logic typed,
                           input result_t typed_res);
    if (!src_steady && $urandom_range(0, 99) < 37) begin
      word_ch.valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < 37);
    end
    word_ch.valid      <= 1'b1;
    word_ch.code_word  <= cw;
    word_ch.final_word <= fin;
    do begin
      @(posedge clk);
    end while (word_ch.ready !== 1'b1);
    if (!skipping)
      decoded_words++;
    word_results.delete();
    decode_word(cw, fin);
    if (typed)
      awaited_results.insert(awaited_results.size(), typed_res);
    else
      foreach (word_results[i]) awaited_results.insert(awaited_results.size(),
                                                       word_results[i]);
  endtask

  // Waits until every expected result word has come out, then lets the
  // decoder finish any word that makes no result. Leftovers are failures.
  task automatic drain();
    int waited;
    word_ch.valid <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_results.size());
      mismatches++;
      awaited_results.delete();
    end
  endtask

  // The capacity register is only touched while the decoder is idle.
  task automatic set_capacity(input logic [16:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
  endtask

  task automatic queue_word(input logic [31:0] cw, input logic fin);
    plan_t p;
    p.code_word  = cw;
    p.final_word = fin;
    word_plan.insert(word_plan.size(), p);
  endtask

  task automatic send_plan();
    plan_t p;
    while (word_plan.size() != 0) begin
      p = word_plan.pop_front();
      send_word(p.code_word, p.final_word, 1'b0, '0);
    end
  endtask

  // Plans one random stream. Most tokens are literals and legal matches so
  // that streams run deep; a few are noise: arbitrary words, bad lengths,
  // bad distances, a final mark in the wrong place, or an end code without
  // the final mark followed by words to be skipped.
  task automatic plan_stream();
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    int          tokens;
    made   = 0;
    tokens = $urandom_range(1, 16);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || (made == 0 && pick < 94)) begin
        queue_word($urandom_range(0, 255), 1'b0);
        made++;
      end else if (pick < 94) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_LEN) : $urandom_range(0, 6);
        queue_word(LEN_BIAS + len, 1'b0);
        queue_word(($urandom_range(0, 5) == 0) ? made : $urandom_range(1, made), 1'b0);
        made += len;
      end else begin
        case ($urandom_range(0, 5))
          0: queue_word($urandom, 1'b0);
          1: queue_word($urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                             : LEN_BIAS + MAX_LEN + 1 + $urandom_range(0, 999),
                        1'b0);
          2: begin
            queue_word(LEN_BIAS + $urandom_range(0, MAX_LEN), 1'b0);
            case ($urandom_range(0, 2))
              0: queue_word(32'd0, 1'b0);
              1: queue_word(made + 1 + $urandom_range(0, 50), 1'b0);
              default: queue_word($urandom | 32'h0001_0001, 1'b0);
            endcase
          end
          3: begin
            queue_word($urandom_range(0, 1) ? $urandom : $urandom_range(0, 255), 1'b1);
            return;
          end
          4: begin
            queue_word(lztd_pkg::END_CODE, 1'b0);
            repeat ($urandom_range(0, 3)) queue_word($urandom, 1'b0);
            queue_word($urandom, 1'b1);
            return;
          end
          default: begin
            queue_word(LEN_BIAS + $urandom_range(0, MAX_LEN), 1'b0);
            queue_word($urandom_range(0, made + 2), 1'b1);
            return;
          end
        endcase
      end
    end
    queue_word(lztd_pkg::END_CODE, 1'b1);
  endtask

  initial begin : stimulus
    result_t     typed_res;
    logic [16:0] cap_pick;
    bit          pressure_done;

    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    word_ch.valid      <= 1'b0;
    word_ch.code_word  <= '0;
    word_ch.final_word <= 1'b0;
    mismatches    = 0;
    hold_cycles   = 0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    pressure_done = 1'b0;
    cap_reg       = lztd_pkg::CAP_LIMIT;
    skipping      = 1'b0;
    open_stream();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (script_rows[i]) begin
      if (script_rows[i].op == ROW_CAP) begin
        set_capacity(script_rows[i].code_word[16:0]);
      end else begin
        typed_res.kind       = script_rows[i].kind;
        typed_res.data_byte  = script_rows[i].data_byte;
        typed_res.byte_count = script_rows[i].byte_count;
        typed_res.run_last   = 1'b1;
        send_word(script_rows[i].code_word, script_rows[i].final_word,
                  script_rows[i].typed, typed_res);
      end
    end

    // Random streams under four capacity settings: a tight one where
    // overflows are common, the full limit, a random 17-bit value (often
    // above the limit), and a moderate one. The third phase runs with no
    // idling on either side; the second carries the long sink stall.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       cap_pick = $urandom_range(0, 48);
        1:       cap_pick = lztd_pkg::CAP_LIMIT;
        2:       cap_pick = 17'($urandom);
        default: cap_pick = $urandom_range(49, 700);
      endcase
      set_capacity(cap_pick);
      src_steady    = (ph == 2);
      sink_steady   = (ph == 2);
      decoded_words = 0;
      while (decoded_words < PHASE_WORDS) begin
        plan_stream();
        if (ph == 1 && !pressure_done && decoded_words >= 10) begin
          hold_cycles   = HOLD_CYCLES;
          pressure_done = 1'b1;
        end
        send_plan();
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    drain();

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lztd_pkg.sv
rtl/core/lztd_in_if.sv
rtl/core/lztd_out_if.sv
rtl/core/lztd_history.sv
rtl/core/lz_token_stream_decoder_unit.sv
sim/testbench.sv
